@@ sv/field_section_byte_parser_top_macros.svh @@
// Assertion macros used by the field section byte parser checker.
`ifndef FIELD_SECTION_BYTE_PARSER_TOP_MACROS_SVH
`define FIELD_SECTION_BYTE_PARSER_TOP_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define FSBP_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked across reset.
`define FSBP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/fsbp_pkg.sv @@
// Package with the types and constants of the field section byte parser.
`timescale 1ns / 1ps

package fsbp_pkg;

  localparam int TABLE_ENTRIES = 10;
  localparam logic [7:0] PREFIX_LITERAL = 8'h20;
  localparam int FIFO_DEPTH = 4;
  localparam int MAX_RESULTS = 3;

  typedef enum logic [2:0] {
    KIND_INDEX    = 3'd0,
    KIND_NAME     = 3'd1,
    KIND_VALUE    = 3'd2,
    KIND_LIT_END  = 3'd3,
    KIND_SECT_OK  = 3'd4,
    KIND_SECT_ERR = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ERR_BAD_INDEX   = 2'd0,
    ERR_MALFORMED   = 2'd1,
    ERR_TRUNC_NAME  = 2'd2,
    ERR_TRUNC_VALUE = 2'd3
  } err_t;

  typedef enum logic [2:0] {
    PH_PREFIX       = 3'd0,
    PH_VARINT_FIRST = 3'd1,
    PH_VARINT_MORE  = 3'd2,
    PH_NAME_LEN     = 3'd3,
    PH_NAME         = 3'd4,
    PH_VALUE_LEN    = 3'd5,
    PH_VALUE        = 3'd6
  } phase_t;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] entry_index;
    logic [7:0] text_byte;
    err_t       error_code;
    logic       last_of_run;
  } result_t;

endpackage

@@ sv/field_section_byte_parser_top.sv @@
// Top level of the field section byte parser: byte decoder and result queue.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------------------
//   in      | input     | in_valid, in_stall | data_byte, last_byte
//   out     | output    | out_valid, out_stall | kind, entry_index, text_byte, error_code,
//           |           |                    | last_of_run
//
// Each input beat is decoded in the cycle it is accepted and its zero to three results
// are written into a four-entry result queue; the output takes one result per cycle unless
// out_stall is high. While out_stall is low, one byte per cycle is sustained if each byte
// gives at most one result; one result per cycle of drain sets the rate for two or three.
// in_stall is high while the queue holds more than one result.
// Synchronous reset empties the queue and returns the decoder to the prefix phase.
`timescale 1ns / 1ps

module field_section_byte_parser_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] kind,
  output logic [3:0] entry_index,
  output logic [7:0] text_byte,
  output logic [1:0] error_code,
  output logic       last_of_run
);

  localparam int PtrW = $clog2(fsbp_pkg::FIFO_DEPTH);
  localparam int CntW = $clog2(fsbp_pkg::FIFO_DEPTH + 1);
  localparam int ResW = $clog2(fsbp_pkg::MAX_RESULTS + 1);

  fsbp_pkg::phase_t phase, phase_next;
  logic [3:0]       acc, acc_next;
  logic             big, big_next;
  logic [2:0]       vleft, vleft_next;
  logic [7:0]       len, len_next;
  logic             disc, disc_next;
  fsbp_pkg::err_t   code, code_next;

  fsbp_pkg::result_t res [fsbp_pkg::MAX_RESULTS];
  logic [ResW-1:0]   nres;
  logic              finish;

  fsbp_pkg::result_t fifo [fsbp_pkg::FIFO_DEPTH];
  logic [PtrW-1:0]   wptr, rptr;
  logic [CntW-1:0]   count;
  logic              accept, pop;
  fsbp_pkg::result_t head;

  assign accept = in_valid & ~in_stall;
  assign pop    = out_valid & ~out_stall;
  assign in_stall  = (count > CntW'(1));
  assign out_valid = (count != '0);
  assign head = fifo[rptr];

  assign kind        = head.kind;
  assign entry_index = head.entry_index;
  assign text_byte   = head.text_byte;
  assign error_code  = head.error_code;
  assign last_of_run = head.last_of_run;

  always_comb begin
    phase_next = phase;
    acc_next   = acc;
    big_next   = big;
    vleft_next = vleft;
    len_next   = len;
    disc_next  = disc;
    code_next  = code;
    finish     = 1'b0;
    nres       = '0;
    for (int i = 0; i < fsbp_pkg::MAX_RESULTS; i++) begin
      res[i] = '{kind: fsbp_pkg::KIND_INDEX, entry_index: 4'd0, text_byte: 8'd0,
                 error_code: fsbp_pkg::ERR_BAD_INDEX, last_of_run: 1'b0};
    end

    if (!disc) begin
      case (phase)
        fsbp_pkg::PH_PREFIX: begin
          if (data_byte[7]) begin
            phase_next = fsbp_pkg::PH_VARINT_FIRST;
          end else if (data_byte == fsbp_pkg::PREFIX_LITERAL) begin
            phase_next = fsbp_pkg::PH_NAME_LEN;
          end else begin
            disc_next = 1'b1;
            code_next = fsbp_pkg::ERR_MALFORMED;
          end
        end
        fsbp_pkg::PH_VARINT_FIRST: begin
          // The integer can never exceed 62 bits, so only its low nibble and
          // a flag for any higher set bit are kept.
          acc_next = data_byte[3:0];
          big_next = |data_byte[5:4];
          case (data_byte[7:6])
            2'd0:    vleft_next = 3'd0;
            2'd1:    vleft_next = 3'd1;
            2'd2:    vleft_next = 3'd3;
            default: vleft_next = 3'd7;
          endcase
          if (data_byte[7:6] == 2'd0) begin
            finish = 1'b1;
          end else begin
            phase_next = fsbp_pkg::PH_VARINT_MORE;
          end
        end
        fsbp_pkg::PH_VARINT_MORE: begin
          acc_next   = data_byte[3:0];
          big_next   = big | (acc != 4'd0) | (|data_byte[7:4]);
          vleft_next = vleft - 3'd1;
          if (vleft_next == 3'd0) begin
            finish = 1'b1;
          end
        end
        fsbp_pkg::PH_NAME_LEN: begin
          len_next   = data_byte;
          phase_next = (data_byte == 8'd0) ? fsbp_pkg::PH_VALUE_LEN : fsbp_pkg::PH_NAME;
        end
        fsbp_pkg::PH_NAME: begin
          res[nres].kind      = fsbp_pkg::KIND_NAME;
          res[nres].text_byte = data_byte;
          nres = nres + ResW'(1);
          len_next = len - 8'd1;
          if (len_next == 8'd0) begin
            phase_next = fsbp_pkg::PH_VALUE_LEN;
          end
        end
        fsbp_pkg::PH_VALUE_LEN: begin
          len_next = data_byte;
          if (data_byte == 8'd0) begin
            res[nres].kind = fsbp_pkg::KIND_LIT_END;
            nres = nres + ResW'(1);
            phase_next = fsbp_pkg::PH_PREFIX;
          end else begin
            phase_next = fsbp_pkg::PH_VALUE;
          end
        end
        fsbp_pkg::PH_VALUE: begin
          res[nres].kind      = fsbp_pkg::KIND_VALUE;
          res[nres].text_byte = data_byte;
          nres = nres + ResW'(1);
          len_next = len - 8'd1;
          if (len_next == 8'd0) begin
            res[nres].kind = fsbp_pkg::KIND_LIT_END;
            nres = nres + ResW'(1);
            phase_next = fsbp_pkg::PH_PREFIX;
          end
        end
        default: begin
          phase_next = fsbp_pkg::PH_PREFIX;
        end
      endcase
    end

    if (finish) begin
      if (big_next || (32'(acc_next) >= fsbp_pkg::TABLE_ENTRIES)) begin
        disc_next = 1'b1;
        code_next = fsbp_pkg::ERR_BAD_INDEX;
      end else begin
        res[nres].kind        = fsbp_pkg::KIND_INDEX;
        res[nres].entry_index = acc_next;
        nres = nres + ResW'(1);
      end
      phase_next = fsbp_pkg::PH_PREFIX;
      acc_next   = 4'd0;
      big_next   = 1'b0;
      vleft_next = 3'd0;
    end

    if (last_byte) begin
      if (!disc_next) begin
        if (phase == fsbp_pkg::PH_NAME_LEN || phase_next == fsbp_pkg::PH_NAME_LEN) begin
          disc_next = 1'b1;
          code_next = fsbp_pkg::ERR_MALFORMED;
        end else if (phase_next inside {fsbp_pkg::PH_VARINT_FIRST,
                                        fsbp_pkg::PH_VARINT_MORE}) begin
          disc_next = 1'b1;
          code_next = fsbp_pkg::ERR_BAD_INDEX;
        end else if (phase_next inside {fsbp_pkg::PH_NAME, fsbp_pkg::PH_VALUE_LEN}) begin
          disc_next = 1'b1;
          code_next = fsbp_pkg::ERR_TRUNC_NAME;
        end else if (phase_next == fsbp_pkg::PH_VALUE) begin
          disc_next = 1'b1;
          code_next = fsbp_pkg::ERR_TRUNC_VALUE;
        end
      end
      if (disc_next) begin
        res[nres].kind       = fsbp_pkg::KIND_SECT_ERR;
        res[nres].error_code = code_next;
      end else begin
        res[nres].kind = fsbp_pkg::KIND_SECT_OK;
      end
      nres = nres + ResW'(1);
      phase_next = fsbp_pkg::PH_PREFIX;
      acc_next   = 4'd0;
      big_next   = 1'b0;
      vleft_next = 3'd0;
      len_next   = 8'd0;
      disc_next  = 1'b0;
      code_next  = fsbp_pkg::ERR_BAD_INDEX;
    end

    if (nres != '0) begin
      res[nres - ResW'(1)].last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= fsbp_pkg::PH_PREFIX;
      acc   <= 4'd0;
      big   <= 1'b0;
      vleft <= 3'd0;
      len   <= 8'd0;
      disc  <= 1'b0;
      code  <= fsbp_pkg::ERR_BAD_INDEX;
    end else if (accept) begin
      phase <= phase_next;
      acc   <= acc_next;
      big   <= big_next;
      vleft <= vleft_next;
      len   <= len_next;
      disc  <= disc_next;
      code  <= code_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < fsbp_pkg::MAX_RESULTS; i++) begin
        if (ResW'(i) < nres) begin
          fifo[PtrW'(wptr + PtrW'(i))] <= res[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (accept) begin
        wptr <= PtrW'(wptr + PtrW'(nres));
      end
      if (pop) begin
        rptr <= rptr + PtrW'(1);
      end
      count <= count + (accept ? CntW'(nres) : CntW'(0)) - (pop ? CntW'(1) : CntW'(0));
    end
  end

endmodule

@@ sv/fsbp_checker.sv @@
// Port-level assertion checker for the field section byte parser, with its bind.
`timescale 1ns / 1ps
`include "field_section_byte_parser_top_macros.svh"

module fsbp_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] data_byte,
  input logic       last_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] kind,
  input logic [3:0] entry_index,
  input logic [7:0] text_byte,
  input logic [1:0] error_code,
  input logic       last_of_run
);

  logic        out_held;
  logic        index_beat;
  logic        sect_end;
  logic        name_mid;
  logic        sect_err;
  logic [17:0] payload;

  assign out_held   = out_valid && out_stall;
  assign index_beat = out_valid && kind == fsbp_pkg::KIND_INDEX;
  assign sect_end   = out_valid && (kind == fsbp_pkg::KIND_SECT_OK ||
                                    kind == fsbp_pkg::KIND_SECT_ERR);
  assign name_mid   = out_valid && !out_stall && kind == fsbp_pkg::KIND_NAME && !last_of_run;
  assign sect_err   = out_valid && kind == fsbp_pkg::KIND_SECT_ERR;
  assign payload    = {kind, entry_index, text_byte, error_code, last_of_run};

  // A result beat held back by the consumer stays on the port unchanged.
  `FSBP_ASSERT(a_out_hold, clk, rst, out_held |=> out_valid && $stable(payload), "stalled result beat changed")

  `FSBP_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "result queue not empty after reset")

  `FSBP_ASSERT(a_index_range, clk, rst, index_beat |-> 32'(entry_index) < fsbp_pkg::TABLE_ENTRIES, "indexed field beyond the static table")

  `FSBP_ASSERT(a_section_end_last, clk, rst, sect_end |-> last_of_run, "section end result not marked last of run")

  `FSBP_ASSERT(a_name_alone, clk, rst, name_mid |=> sect_err, "name byte followed by an unexpected result")

endmodule

bind field_section_byte_parser_top fsbp_checker u_fsbp_checker (.*);

@@ tb/testbench.sv @@
// Self-checking testbench for the field section byte parser with a predicting scoreboard.
`timescale 1ns / 1ps

module testbench;

  localparam int RANDOM_BEATS = 380;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 300000;

  class field_decode_checker;
    fsbp_pkg::phase_t  phase;
    logic [61:0]       accum;
    logic [2:0]        bytes_left;
    logic [7:0]        length_left;
    bit                discarding;
    fsbp_pkg::err_t    held_error;
    fsbp_pkg::result_t expected_fields[$];
    fsbp_pkg::result_t beat_fields[$];
    int                failures;

    function new();
      restart();
      failures = 0;
    endfunction

    function void restart();
      phase       = fsbp_pkg::PH_PREFIX;
      accum       = '0;
      bytes_left  = '0;
      length_left = '0;
      discarding  = 1'b0;
      held_error  = fsbp_pkg::ERR_BAD_INDEX;
    endfunction

    function void emit(fsbp_pkg::kind_t k, logic [3:0] idx, logic [7:0] text,
                       fsbp_pkg::err_t code);
      fsbp_pkg::result_t r;
      r.kind        = k;
      r.entry_index = idx;
      r.text_byte   = text;
      r.error_code  = code;
      r.last_of_run = 1'b0;
      beat_fields = {beat_fields, r};
    endfunction

    function void raise_error(fsbp_pkg::err_t code);
      discarding = 1'b1;
      held_error = code;
    endfunction

    function void close_index();
      if (accum >= fsbp_pkg::TABLE_ENTRIES) raise_error(fsbp_pkg::ERR_BAD_INDEX);
      else emit(fsbp_pkg::KIND_INDEX, accum[3:0], 8'h00, fsbp_pkg::ERR_BAD_INDEX);
      phase      = fsbp_pkg::PH_PREFIX;
      accum      = '0;
      bytes_left = '0;
    endfunction

    // Works out the results of one accepted input beat and queues them.
    function void note_byte(logic [7:0] b, logic is_last);
      fsbp_pkg::phase_t start_phase;
      start_phase = phase;
      beat_fields.delete();
      if (!discarding) begin
        case (phase)
          fsbp_pkg::PH_PREFIX: begin
            if (b[7]) phase = fsbp_pkg::PH_VARINT_FIRST;
            else if (b == fsbp_pkg::PREFIX_LITERAL) phase = fsbp_pkg::PH_NAME_LEN;
            else raise_error(fsbp_pkg::ERR_MALFORMED);
          end
          fsbp_pkg::PH_VARINT_FIRST: begin
            accum = 62'(b[5:0]);
            case (b[7:6])
              2'd0: bytes_left = 3'd0;
              2'd1: bytes_left = 3'd1;
              2'd2: bytes_left = 3'd3;
              default: bytes_left = 3'd7;
            endcase
            if (bytes_left == 3'd0) close_index();
            else phase = fsbp_pkg::PH_VARINT_MORE;
          end
          fsbp_pkg::PH_VARINT_MORE: begin
            accum = {accum[53:0], b};
            bytes_left = bytes_left - 3'd1;
            if (bytes_left == 3'd0) close_index();
          end
          fsbp_pkg::PH_NAME_LEN: begin
            length_left = b;
            phase = (b == 8'd0) ? fsbp_pkg::PH_VALUE_LEN : fsbp_pkg::PH_NAME;
          end
          fsbp_pkg::PH_NAME: begin
            emit(fsbp_pkg::KIND_NAME, 4'd0, b, fsbp_pkg::ERR_BAD_INDEX);
            length_left = length_left - 8'd1;
            if (length_left == 8'd0) phase = fsbp_pkg::PH_VALUE_LEN;
          end
          fsbp_pkg::PH_VALUE_LEN: begin
            length_left = b;
            if (b == 8'd0) begin
              emit(fsbp_pkg::KIND_LIT_END, 4'd0, 8'h00, fsbp_pkg::ERR_BAD_INDEX);
              phase = fsbp_pkg::PH_PREFIX;
            end else begin
              phase = fsbp_pkg::PH_VALUE;
            end
          end
          fsbp_pkg::PH_VALUE: begin
            emit(fsbp_pkg::KIND_VALUE, 4'd0, b, fsbp_pkg::ERR_BAD_INDEX);
            length_left = length_left - 8'd1;
            if (length_left == 8'd0) begin
              emit(fsbp_pkg::KIND_LIT_END, 4'd0, 8'h00, fsbp_pkg::ERR_BAD_INDEX);
              phase = fsbp_pkg::PH_PREFIX;
            end
          end
          default: phase = fsbp_pkg::PH_PREFIX;
        endcase
      end
      if (is_last) begin
        if (!discarding) begin
          if (start_phase == fsbp_pkg::PH_NAME_LEN || phase == fsbp_pkg::PH_NAME_LEN)
            raise_error(fsbp_pkg::ERR_MALFORMED);
          else if (phase == fsbp_pkg::PH_VARINT_FIRST || phase == fsbp_pkg::PH_VARINT_MORE)
            raise_error(fsbp_pkg::ERR_BAD_INDEX);
          else if (phase == fsbp_pkg::PH_NAME || phase == fsbp_pkg::PH_VALUE_LEN)
            raise_error(fsbp_pkg::ERR_TRUNC_NAME);
          else if (phase == fsbp_pkg::PH_VALUE)
            raise_error(fsbp_pkg::ERR_TRUNC_VALUE);
        end
        if (discarding) emit(fsbp_pkg::KIND_SECT_ERR, 4'd0, 8'h00, held_error);
        else emit(fsbp_pkg::KIND_SECT_OK, 4'd0, 8'h00, fsbp_pkg::ERR_BAD_INDEX);
        restart();
      end
      if (beat_fields.size() > 0) beat_fields[beat_fields.size() - 1].last_of_run = 1'b1;
      foreach (beat_fields[i]) expected_fields = {expected_fields, beat_fields[i]};
    endfunction

    function void check_result(fsbp_pkg::result_t got);
      fsbp_pkg::result_t want;
      if (expected_fields.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: unexpected result kind %0d idx %0d text %02h code %0d last %0b",
                   $time, got.kind, got.entry_index, got.text_byte, got.error_code,
                   got.last_of_run);
        return;
      end
      want = expected_fields.pop_front();
      if (got.kind !== want.kind || got.entry_index !== want.entry_index ||
          got.text_byte !== want.text_byte || got.error_code !== want.error_code ||
          got.last_of_run !== want.last_of_run) begin
        failures++;
        if (failures <= 10)
          $display("%0t: mismatch, expected kind %0d idx %0d text %02h code %0d last %0b, %s",
                   $time, want.kind, want.entry_index, want.text_byte, want.error_code,
                   want.last_of_run,
                   $sformatf("got kind %0d idx %0d text %02h code %0d last %0b",
                             got.kind, got.entry_index, got.text_byte, got.error_code,
                             got.last_of_run));
      end
    endfunction

    function int outstanding();
      return expected_fields.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte = 8'h00;
  logic       last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] kind;
  logic [3:0] entry_index;
  logic [7:0] text_byte;
  logic [1:0] error_code;
  logic       last_of_run;

  field_decode_checker decoder = new();
  logic [7:0] section_bytes[$];
  bit  idle_on = 1'b1;
  bit  hold_now = 1'b0;
  bit  hold_done = 1'b0;
  bit  long_done = 1'b0;
  int  beats_sent = 0;
  int  cycle_count = 0;

  field_section_byte_parser_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind(kind),
    .entry_index(entry_index),
    .text_byte(text_byte),
    .error_code(error_code),
    .last_of_run(last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin : watch
    fsbp_pkg::result_t got;
    if (!rst) begin
      if (in_valid && !in_stall) decoder.note_byte(data_byte, last_byte);
      if (out_valid && !out_stall) begin
        got.kind        = fsbp_pkg::kind_t'(kind);
        got.entry_index = entry_index;
        got.text_byte   = text_byte;
        got.error_code  = fsbp_pkg::err_t'(error_code);
        got.last_of_run = last_of_run;
        decoder.check_result(got);
      end
    end
  end

  // The receiver normally stalls at random, and once holds off for a long stretch.
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_now) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_now = 1'b0;
      end else begin
        out_stall <= idle_on && ($urandom_range(0, 99) < 24);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_beat(input logic [7:0] b, input logic is_last);
    while (idle_on && $urandom_range(0, 99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= is_last;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  task automatic send_section();
    foreach (section_bytes[i]) send_beat(section_bytes[i], i == section_bytes.size() - 1);
    section_bytes.delete();
  endtask

  function automatic void add_byte(logic [7:0] b);
    section_bytes = {section_bytes, b};
  endfunction

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 0;
    if (r < 90) return $urandom_range(1, 6);
    return $urandom_range(7, 24);
  endfunction

  function automatic void append_index();
    int width_code;
    int nbytes;
    int value_bits;
    longint unsigned value;
    logic [7:0] b;
    width_code = $urandom_range(0, 3);
    nbytes     = 1 << width_code;
    value_bits = 6 + 8 * (nbytes - 1);
    if ($urandom_range(0, 99) < 85) value = $urandom_range(0, fsbp_pkg::TABLE_ENTRIES - 1);
    else value = {$urandom, $urandom} & ((64'd1 << value_bits) - 64'd1);
    add_byte({1'b1, 7'($urandom)});
    for (int i = nbytes - 1; i >= 0; i--) begin
      b = 8'(value >> (8 * i));
      if (i == nbytes - 1) b[7:6] = 2'(width_code);
      add_byte(b);
    end
  endfunction

  function automatic void append_literal();
    int name_len;
    int value_len;
    name_len  = pick_length();
    value_len = pick_length();
    if (!long_done && $urandom_range(0, 29) == 0) begin
      name_len  = 255;
      long_done = 1'b1;
    end
    add_byte(fsbp_pkg::PREFIX_LITERAL);
    add_byte(8'(name_len));
    repeat (name_len) add_byte(8'($urandom));
    add_byte(8'(value_len));
    repeat (value_len) add_byte(8'($urandom));
  endfunction

  initial begin : stimulus
    int r;
    int cut;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed sections: extremes, every result kind and each error path.
    section_bytes = '{8'hFF, 8'h09};
    send_section();
    section_bytes = '{8'h80, 8'h80, 8'h00, 8'h00, 8'h0A};
    send_section();
    section_bytes = '{8'h20, 8'h01, 8'h41, 8'h02, 8'hFE, 8'hFF};
    send_section();
    section_bytes = '{8'h7F};
    send_section();
    section_bytes = '{8'h20};
    send_section();
    section_bytes = '{8'h80, 8'h40};
    send_section();
    section_bytes = '{8'h20, 8'h01, 8'h00};
    send_section();
    section_bytes = '{8'h20, 8'h00, 8'h03, 8'h55};
    send_section();

    // Mostly well-formed sections with random content, some noise and cut sections.
    beats_sent = 0;
    while (beats_sent < RANDOM_BEATS) begin
      idle_on = !(beats_sent >= 170 && beats_sent < 250);
      if (!hold_done && beats_sent >= 90) begin
        hold_now  = 1'b1;
        hold_done = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 8) begin
        repeat ($urandom_range(1, 5)) add_byte(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 1) == 0) append_index();
          else append_literal();
        end
        if (r >= 80) begin
          cut = $urandom_range(1, section_bytes.size());
          while (section_bytes.size() > cut) void'(section_bytes.pop_back());
        end
      end
      send_section();
    end

    in_valid <= 1'b0;
    idle_on = 1'b1;
    @(posedge clk);
    while (decoder.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (decoder.failures == 0 && decoder.outstanding() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+sv
sv/fsbp_pkg.sv
sv/field_section_byte_parser_top.sv
sv/fsbp_checker.sv
tb/testbench.sv
